FILE: hw/rtl/xspi_manual_command_nor_flash_defines.svh
// Assertion macros for the manual-command flash controller checks.
// Used by the checker file; no other dependencies.
`ifndef XSPI_MANUAL_COMMAND_NOR_FLASH_DEFINES_SVH
`define XSPI_MANUAL_COMMAND_NOR_FLASH_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define XMC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define XMC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/xspimc_pkg.sv
// Shared types and constants for the manual-command flash controller.
// No dependencies.
package xspimc_pkg;

  localparam int FLASH_BYTES_DEF  = 65536;
  localparam int SECTOR_BYTES_DEF = 4096;
  localparam int WIN_WORDS        = 128;
  localparam int IN_W             = 40;
  localparam int OUT_W            = 32;
  localparam int JEDEC_W          = 24;

  localparam logic [JEDEC_W-1:0] JEDEC_RST = 24'h1A5A9D;
  localparam logic [7:0]         ERASED    = 8'hFF;
  localparam logic [31:0]        FLASH_STATUS_VAL = 32'h0000_0002;

  // window word indexes (byte offsets 0x070, 0x080, 0x190, 0x194 etc.)
  localparam logic [6:0] W_CTRL = 7'd28;
  localparam logic [6:0] W_DESC = 7'd32;
  localparam logic [6:0] W_ADDR = 7'd33;
  localparam logic [6:0] W_D0   = 7'd34;
  localparam logic [6:0] W_D1   = 7'd35;
  localparam logic [6:0] W_STAT = 7'd100;
  localparam logic [6:0] W_CLR  = 7'd101;

  // flash opcodes
  localparam logic [7:0] OPC_RDID  = 8'h9F;
  localparam logic [7:0] OPC_RDSR  = 8'h05;
  localparam logic [7:0] OPC_READ  = 8'h03;
  localparam logic [7:0] OPC_PROG  = 8'h02;
  localparam logic [7:0] OPC_ERASE = 8'h20;

  localparam logic [1:0] CSIZE_HI = 2'd1;
  localparam logic [1:0] CSIZE_LO = 2'd2;

  // APB register index 0 lives at paddr bit 2 clear
  localparam logic CFG_IDX_JEDEC = 1'b0;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RESP,
    ST_CMD,
    ST_RD_REQ,
    ST_RD_CAP,
    ST_PG_REQ,
    ST_PG_WR,
    ST_ERASE,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ID,
    OP_STAT,
    OP_READ,
    OP_PROG,
    OP_ERASE
  } op_t;

  typedef struct packed {
    logic capture;
    logic exec_wr;
    logic load_out;
    logic setup;
    logic set_id;
    logic set_stat;
    logic rd_req;
    logic rd_cap;
    logic rd_commit;
    logic pg_req;
    logic pg_wr;
    logic er_step;
    logic clr_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic start;
    logic base_ok;
    logic idx_end;
    logic er_last;
    logic clr_last;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: hw/rtl/xspimc_apb.sv
// APB configuration register block: holds the ID bytes.
// Depends on xspimc_pkg.
module xspimc_apb (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [2:0]                    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready,
  output logic [xspimc_pkg::JEDEC_W-1:0] jedec
);
  import xspimc_pkg::*;

  logic [JEDEC_W-1:0] jedec_r, jedec_nxt;
  logic               wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && (cfg_paddr[2] == CFG_IDX_JEDEC);

  always_comb begin
    jedec_nxt = jedec_r;
    if (wr_en) begin
      jedec_nxt = cfg_pwdata[JEDEC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jedec_r <= JEDEC_RST;
    end else begin
      jedec_r <= jedec_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_JEDEC) ? {{(32-JEDEC_W){1'b0}}, jedec_r} : 32'd0;
  assign jedec = jedec_r;

endmodule

FILE: hw/rtl/xspimc_ctrl.sv
// Controller state machine: sequences bus accesses, flash commands and the
// post-reset clearing pass. Depends on xspimc_pkg.
module xspimc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  xspimc_pkg::dp_stat_t stat,
  output xspimc_pkg::dp_cmd_t  cmd
);
  import xspimc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (stat.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_tvalid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (stat.start) state_nxt = ST_CMD;
        else if (stat.out_free) state_nxt = ST_IDLE;
        else state_nxt = ST_RESP;
      end
      ST_RESP:   if (stat.out_free) state_nxt = ST_IDLE;
      ST_CMD: begin
        unique case (stat.op)
          OP_READ:  state_nxt = ST_RD_REQ;
          OP_PROG:  state_nxt = ST_PG_REQ;
          OP_ERASE: state_nxt = stat.base_ok ? ST_ERASE : ST_DONE;
          default:  state_nxt = ST_DONE;
        endcase
      end
      ST_RD_REQ: state_nxt = stat.idx_end ? ST_DONE : ST_RD_CAP;
      ST_RD_CAP: state_nxt = ST_RD_REQ;
      ST_PG_REQ: state_nxt = stat.idx_end ? ST_DONE : ST_PG_WR;
      ST_PG_WR:  state_nxt = ST_PG_REQ;
      ST_ERASE:  if (stat.er_last) state_nxt = ST_DONE;
      ST_DONE:   if (stat.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_EXEC: begin
        cmd.exec_wr  = 1'b1;
        cmd.load_out = !stat.start && stat.out_free;
      end
      ST_RESP: cmd.load_out = stat.out_free;
      ST_CMD: begin
        cmd.setup    = 1'b1;
        cmd.set_id   = (stat.op == OP_ID);
        cmd.set_stat = (stat.op == OP_STAT);
      end
      ST_RD_REQ: begin
        cmd.rd_commit = stat.idx_end;
        cmd.rd_req    = !stat.idx_end;
      end
      ST_RD_CAP: cmd.rd_cap = 1'b1;
      ST_PG_REQ: cmd.pg_req = !stat.idx_end;
      ST_PG_WR:  cmd.pg_wr = 1'b1;
      ST_ERASE:  cmd.er_step = 1'b1;
      ST_DONE: begin
        cmd.finish   = 1'b1;
        cmd.load_out = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

FILE: hw/rtl/xspimc_dp.sv
// Datapath: register window, flash byte store, command counters and the
// result register. Depends on xspimc_pkg.
module xspimc_dp #(
  parameter int FLASH_BYTES  = xspimc_pkg::FLASH_BYTES_DEF,
  parameter int SECTOR_BYTES = xspimc_pkg::SECTOR_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [xspimc_pkg::IN_W-1:0]    in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [xspimc_pkg::OUT_W-1:0]   out_tdata,
  input  logic [xspimc_pkg::JEDEC_W-1:0] jedec,
  input  xspimc_pkg::dp_cmd_t            cmd,
  output xspimc_pkg::dp_stat_t           stat
);
  import xspimc_pkg::*;

  localparam int          FA_W       = $clog2(FLASH_BYTES);
  localparam int          SEC_W      = $clog2(SECTOR_BYTES);
  localparam logic [31:0] FLASH_LIM  = 32'(FLASH_BYTES);
  localparam logic [31:0] FLASH_LAST = 32'(FLASH_BYTES - 1);
  localparam logic [31:0] SEC_MASK   = ~32'(SECTOR_BYTES - 1);
  localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(SECTOR_BYTES - 1);
  localparam logic [FA_W-1:0]  CLR_LAST = FA_W'(FLASH_BYTES - 1);

  // captured item
  logic        mode_r;
  logic [6:0]  off_r;
  logic [31:0] wd_r;

  // register window
  logic [31:0]          win_mem [WIN_WORDS];
  logic [WIN_WORDS-1:0] vld_r, vld_nxt;
  logic [31:0]          mem_q_r;
  logic                 mvld_r;
  logic                 mwe;
  logic [31:0] ctrl_r, desc_r, addr_r, d0_r, d1_r, stat_r;
  logic [31:0] ctrl_nxt, desc_nxt, addr_nxt, d0_nxt, d1_nxt, stat_nxt;
  logic        is_special;

  // flash store
  logic [7:0]      flash_mem [FLASH_BYTES];
  logic [7:0]      fq_r;
  logic            rng_r;
  logic            fwe;
  logic [FA_W-1:0] fwa;
  logic [7:0]      fwd;
  logic            f_re;

  // command engine
  logic [FA_W-1:0]  clr_r, clr_nxt;
  logic [3:0]       idx_r, idx_nxt, n_r, n_nxt, n_cl;
  logic [63:0]      dbuf_r, dbuf_nxt;
  logic [31:0]      base_r, base_nxt;
  logic [SEC_W-1:0] eoff_r, eoff_nxt;
  logic [31:0]      fa_full, ea;
  logic             a_in;
  logic [5:0]       bsel;
  logic [7:0]       opcode;
  logic             op_valid;
  op_t              op;

  // result
  logic        ovld_r, ovld_nxt;
  logic [31:0] odata_r, res;

  // ---------------- item capture and window read ----------------
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_tdata[0];
      off_r   <= in_tdata[7:1];
      wd_r    <= in_tdata[39:8];
      mem_q_r <= win_mem[in_tdata[7:1]];
      mvld_r  <= vld_r[in_tdata[7:1]];
    end
  end

  always_comb begin
    unique case (off_r)
      W_CTRL, W_DESC, W_ADDR, W_D0, W_D1, W_STAT, W_CLR: is_special = 1'b1;
      default: is_special = 1'b0;
    endcase
  end

  assign mwe = cmd.exec_wr && mode_r && !is_special;

  always_ff @(posedge clk) begin
    if (mwe) begin
      win_mem[off_r] <= wd_r;
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (mwe) begin
      vld_nxt[off_r] = 1'b1;
    end
  end

  // ---------------- decode ----------------
  assign n_cl = (desc_r[8:5] > 4'd8) ? 4'd8 : desc_r[8:5];

  always_comb begin
    opcode   = 8'd0;
    op_valid = 1'b0;
    unique case (desc_r[1:0])
      CSIZE_HI: begin
        opcode   = desc_r[31:24];
        op_valid = 1'b1;
      end
      CSIZE_LO: begin
        opcode   = desc_r[23:16];
        op_valid = 1'b1;
      end
      default: op_valid = 1'b0;
    endcase
  end

  always_comb begin
    op = OP_NONE;
    if (op_valid) begin
      unique case (opcode)
        OPC_RDID:  op = OP_ID;
        OPC_RDSR:  op = OP_STAT;
        OPC_READ:  op = OP_READ;
        OPC_PROG:  op = OP_PROG;
        OPC_ERASE: op = OP_ERASE;
        default:   op = OP_NONE;
      endcase
    end
  end

  assign fa_full = addr_r + {28'd0, idx_r};
  assign a_in    = fa_full < FLASH_LIM;
  assign ea      = base_r | 32'(eoff_r);
  assign bsel    = {idx_r[2:0], 3'b000};

  // ---------------- window registers ----------------
  always_comb begin
    ctrl_nxt = ctrl_r;
    desc_nxt = desc_r;
    addr_nxt = addr_r;
    d0_nxt   = d0_r;
    d1_nxt   = d1_r;
    stat_nxt = stat_r;
    if (cmd.exec_wr && mode_r) begin
      unique case (off_r)
        W_CTRL:  ctrl_nxt = wd_r;
        W_DESC:  desc_nxt = wd_r;
        W_ADDR:  addr_nxt = wd_r;
        W_D0:    d0_nxt   = wd_r;
        W_D1:    d1_nxt   = wd_r;
        W_STAT:  stat_nxt = wd_r;
        W_CLR:   stat_nxt = stat_r & ~wd_r;
        default: ;
      endcase
    end
    if (cmd.set_id) begin
      d0_nxt = {{(32-JEDEC_W){1'b0}}, jedec};
    end
    if (cmd.set_stat) begin
      d0_nxt = FLASH_STATUS_VAL;
    end
    if (cmd.rd_commit) begin
      d0_nxt = dbuf_r[31:0];
      d1_nxt = dbuf_r[63:32];
    end
    if (cmd.finish) begin
      stat_nxt = stat_r | 32'd1;
      ctrl_nxt = ctrl_r & ~32'd1;
    end
  end

  // ---------------- engine counters ----------------
  always_comb begin
    clr_nxt  = clr_r;
    idx_nxt  = idx_r;
    n_nxt    = n_r;
    dbuf_nxt = dbuf_r;
    base_nxt = base_r;
    eoff_nxt = eoff_r;
    if (cmd.clr_step) begin
      clr_nxt = clr_r + FA_W'(1);
    end
    if (cmd.setup) begin
      idx_nxt  = 4'd0;
      n_nxt    = n_cl;
      dbuf_nxt = (op == OP_READ) ? 64'd0 : {d1_r, d0_r};
      base_nxt = addr_r & SEC_MASK;
      eoff_nxt = '0;
    end
    if (cmd.rd_cap) begin
      dbuf_nxt[bsel +: 8] = rng_r ? fq_r : ERASED;
    end
    if (cmd.rd_cap || cmd.pg_wr) begin
      idx_nxt = idx_r + 4'd1;
    end
    if (cmd.er_step) begin
      eoff_nxt = eoff_r + SEC_W'(1);
    end
  end

  // ---------------- flash port ----------------
  assign f_re = cmd.rd_req || cmd.pg_req;

  always_comb begin
    fwe = 1'b0;
    fwa = fa_full[FA_W-1:0];
    fwd = ERASED;
    if (cmd.clr_step) begin
      fwe = 1'b1;
      fwa = clr_r;
    end else if (cmd.er_step) begin
      fwe = 1'b1;
      fwa = ea[FA_W-1:0];
    end else if (cmd.pg_wr) begin
      fwe = rng_r;
      fwd = fq_r & dbuf_r[bsel +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (fwe) begin
      flash_mem[fwa] <= fwd;
    end
  end

  always_ff @(posedge clk) begin
    if (f_re) begin
      fq_r  <= flash_mem[fa_full[FA_W-1:0]];
      rng_r <= a_in;
    end
  end

  // ---------------- result ----------------
  always_comb begin
    res = 32'd0;
    if (!mode_r) begin
      unique case (off_r)
        W_CTRL:  res = ctrl_r;
        W_DESC:  res = desc_r;
        W_ADDR:  res = addr_r;
        W_D0:    res = d0_r;
        W_D1:    res = d1_r;
        W_STAT:  res = stat_r;
        default: res = mvld_r ? mem_q_r : 32'd0;
      endcase
    end
  end

  always_comb begin
    ovld_nxt = ovld_r;
    if (cmd.load_out) begin
      ovld_nxt = 1'b1;
    end else if (out_tready) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      odata_r <= res;
    end
  end

  // ---------------- control state ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      ctrl_r <= '0;
      desc_r <= '0;
      addr_r <= '0;
      d0_r   <= '0;
      d1_r   <= '0;
      stat_r <= '0;
      clr_r  <= '0;
      idx_r  <= '0;
      n_r    <= '0;
      eoff_r <= '0;
      ovld_r <= 1'b0;
    end else begin
      vld_r  <= vld_nxt;
      ctrl_r <= ctrl_nxt;
      desc_r <= desc_nxt;
      addr_r <= addr_nxt;
      d0_r   <= d0_nxt;
      d1_r   <= d1_nxt;
      stat_r <= stat_nxt;
      clr_r  <= clr_nxt;
      idx_r  <= idx_nxt;
      n_r    <= n_nxt;
      eoff_r <= eoff_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dbuf_r <= dbuf_nxt;
    base_r <= base_nxt;
  end

  assign stat.op       = op;
  assign stat.start    = mode_r && (off_r == W_CTRL) && wd_r[0];
  assign stat.base_ok  = (addr_r & SEC_MASK) < FLASH_LIM;
  assign stat.idx_end  = (idx_r == n_r);
  assign stat.er_last  = (eoff_r == SEC_LAST) || (ea == FLASH_LAST);
  assign stat.clr_last = (clr_r == CLR_LAST);
  assign stat.out_free = !ovld_r || out_tready;

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;

endmodule

FILE: hw/rtl/xspi_manual_command_nor_flash.sv
// Top level of the manual-command NOR flash controller; depends on xspimc_pkg.
// Register read or plain write: executed after capture, result registered once the output is free; one item at a time.
// Commands: ID/status load D0 directly; read and program take n bytes, each with a request
// state then a capture or write state; erase writes one byte per cycle.
// Reset: synchronous; then a clearing pass that sets every flash byte to FFh, with in_tready low.
module xspi_manual_command_nor_flash #(
  parameter int FLASH_BYTES  = xspimc_pkg::FLASH_BYTES_DEF,
  parameter int SECTOR_BYTES = xspimc_pkg::SECTOR_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [0] mode, [7:1] word_offset, [39:8] write_data
  input  logic [xspimc_pkg::IN_W-1:0]  in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [31:0] read_data
  output logic [xspimc_pkg::OUT_W-1:0] out_tdata,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [2:0]                   cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  import xspimc_pkg::*;

  dp_cmd_t              cmd;
  dp_stat_t             stat;
  logic [JEDEC_W-1:0]   jedec;

  xspimc_apb u_apb (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .jedec       (jedec)
  );

  xspimc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  xspimc_dp #(
    .FLASH_BYTES  (FLASH_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .jedec      (jedec),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

FILE: hw/rtl/xspimc_chk.sv
// Port-level checker for the manual-command flash controller, bound to the top.
// Depends on xspimc_pkg and the assertion macro header.
`include "xspi_manual_command_nor_flash_defines.svh"

module xspimc_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [xspimc_pkg::OUT_W-1:0] out_tdata
);
  import xspimc_pkg::*;

  logic [1:0] pend_r;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_r + {1'b0, in_xfer} - {1'b0, out_xfer};
    end
  end

  `XMC_ASSERT_NXT(a_one_at_a_time, in_xfer, !in_tready, "input taken while busy")
  `XMC_ASSERT_IMP(a_no_orphan_out, out_tvalid, pend_r != 2'd0, "result without transfer")
  `XMC_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped")
  `XMC_ASSERT_NXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "result changed")

endmodule

bind xspi_manual_command_nor_flash xspimc_chk u_chk (.*);

FILE: dv/xspi_manual_command_nor_flash_tb.sv
// Self-checking testbench for xspi_manual_command_nor_flash: register window transfers,
// flash commands and jedec_id writes, predicted by an in-bench shadow of window and flash.
// Depends on xspimc_pkg and the xspi_manual_command_nor_flash RTL.
module xspi_manual_command_nor_flash_tb;
  import xspimc_pkg::*;

  localparam logic       ACC_RD      = 1'b0;
  localparam logic       ACC_WR      = 1'b1;
  localparam logic [2:0] ADDR_JEDEC  = 3'd0;
  localparam int         STALL_LIMIT = 4 * (FLASH_BYTES_DEF + SECTOR_BYTES_DEF);
  localparam int         NUM_PROBES  = 26;
  localparam int         PHASE_ITEMS = 375;

  typedef struct packed {
    logic        wr;
    logic [6:0]  off;
    logic [31:0] data;
    logic        typed;
    logic [31:0] rdata;
  } probe_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_psel;
  logic             cfg_penable;
  logic             cfg_pwrite;
  logic [2:0]       cfg_paddr;
  logic [31:0]      cfg_pwdata;
  logic [31:0]      cfg_prdata;
  logic             cfg_pready;

  // side tags that travel with in_tdata: fixed expectation for table rows
  logic             tag_typed;
  logic [31:0]      tag_rdata;

  logic [31:0]      win_img [WIN_WORDS];
  logic [7:0]       flash_img [FLASH_BYTES_DEF];
  logic [23:0]      jedec_val;
  logic [31:0]      rdata_due [$];
  logic [31:0]      got_rdata;
  int               mismatches;
  int               items_sent;
  int               results_seen;
  int               quiet_cycles;
  bit               in_burst;
  bit               out_burst;
  bit               long_hold_done;
  probe_t           probes [NUM_PROBES];

  xspi_manual_command_nor_flash dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40) begin
      $display("mismatch %s: got %h, want %h", what, got, want);
    end
    mismatches++;
  endtask

  function automatic logic [31:0] mk_desc(logic [1:0] cs, logic [7:0] opc, logic [3:0] n);
    return {(cs == CSIZE_HI) ? {opc, 8'h00} : {8'h00, opc}, 7'h00, n, 3'h0, cs};
  endfunction

  function automatic void run_flash_cmd();
    logic [31:0] desc;
    logic [31:0] addr;
    logic [31:0] a;
    logic [31:0] base;
    logic [31:0] d0;
    logic [31:0] d1;
    logic [7:0]  opc;
    logic [7:0]  b;
    bit          has_op;
    int          n;
    desc   = win_img[W_DESC];
    addr   = win_img[W_ADDR];
    n      = desc[8:5];
    has_op = 1'b1;
    opc    = 8'h00;
    if (n > 8) n = 8;
    case (desc[1:0])
      CSIZE_HI: opc = desc[31:24];
      CSIZE_LO: opc = desc[23:16];
      default: has_op = 1'b0;
    endcase
    if (has_op) begin
      case (opc)
        OPC_RDID: win_img[W_D0] = {8'h00, jedec_val};
        OPC_RDSR: win_img[W_D0] = FLASH_STATUS_VAL;
        OPC_READ: begin
          d0 = '0;
          d1 = '0;
          for (int i = 0; i < n; i++) begin
            a = addr + 32'(i);
            b = (a < FLASH_BYTES_DEF) ? flash_img[a] : ERASED;
            if (i < 4) d0[8*i +: 8] = b;
            else d1[8*(i-4) +: 8] = b;
          end
          win_img[W_D0] = d0;
          win_img[W_D1] = d1;
        end
        OPC_PROG: begin
          d0 = win_img[W_D0];
          d1 = win_img[W_D1];
          for (int i = 0; i < n; i++) begin
            a = addr + 32'(i);
            b = (i < 4) ? d0[8*i +: 8] : d1[8*(i-4) +: 8];
            if (a < FLASH_BYTES_DEF) flash_img[a] = flash_img[a] & b;
          end
        end
        OPC_ERASE: begin
          base = addr & ~32'(SECTOR_BYTES_DEF - 1);
          if (base < FLASH_BYTES_DEF) begin
            for (int i = 0; i < SECTOR_BYTES_DEF; i++) begin
              if (base + 32'(i) < FLASH_BYTES_DEF) flash_img[base + 32'(i)] = ERASED;
            end
          end
        end
        default: ;
      endcase
    end
    win_img[W_STAT][0] = 1'b1;
  endfunction

  // returns read_data for one window access and updates the shadow state
  function automatic logic [31:0] access_window(logic wr, logic [6:0] off, logic [31:0] val);
    if (wr == ACC_RD) return win_img[off];
    if (off == W_CLR) begin
      win_img[W_STAT] = win_img[W_STAT] & ~val;
      return '0;
    end
    win_img[off] = val;
    if (off == W_CTRL && val[0]) begin
      run_flash_cmd();
      win_img[W_CTRL][0] = 1'b0;
    end
    return '0;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        got_rdata = access_window(in_tdata[0], in_tdata[7:1], in_tdata[39:8]);
        rdata_due.push_back(tag_typed ? tag_rdata : got_rdata);
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (rdata_due.size() == 0) report_mismatch("unexpected read_data", out_tdata, '0);
        else begin
          got_rdata = rdata_due.pop_front();
          if (out_tdata !== got_rdata) report_mismatch("read_data", out_tdata, got_rdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random back-pressure, bursts of no stall, one long hold-off
  initial begin
    int gap;
    out_tready <= 1'b0;
    forever begin
      if (!long_hold_done && results_seen >= 500) begin
        long_hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      gap = out_burst ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic push_item(input logic wr, input logic [6:0] off, input logic [31:0] data,
                           input logic typed = 1'b0, input logic [31:0] rdata = '0);
    int gap;
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {data, off, wr};
    tag_typed <= typed;
    tag_rdata <= rdata;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // called at the transfer edge; sender stays quiet until every result is back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (rdata_due.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [2:0] a, input logic [31:0] d,
                            output logic [31:0] rd);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= a;
    cfg_pwdata  <= d;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_addr(int r);
    case (r)
      6: return 32'h0000_FFF0 + 32'($urandom_range(0, 15));
      7: return 32'hFFFF_FFF8 + 32'($urandom_range(0, 7));
      8: return $urandom;
      default: return 32'($urandom_range(0, 32'h2FFF));
    endcase
  endfunction

  task automatic flash_sequence();
    logic [31:0] desc;
    logic [7:0]  opc;
    int          k;
    int          r;
    r = $urandom_range(0, 9);
    if (r != 9) push_item(ACC_WR, W_ADDR, pick_addr(r));
    k = $urandom_range(0, 99);
    if (k < 30) opc = OPC_READ;
    else if (k < 55) opc = OPC_PROG;
    else if (k < 63) opc = OPC_RDID;
    else if (k < 70) opc = OPC_RDSR;
    else if (k < 74) opc = OPC_ERASE;
    else opc = 8'($urandom_range(0, 255));
    if (opc == OPC_PROG) begin
      push_item(ACC_WR, W_D0, $urandom);
      if ($urandom_range(0, 1)) push_item(ACC_WR, W_D1, $urandom);
    end
    desc = $urandom;
    if (k < 90) begin
      desc[1:0] = $urandom_range(0, 1) ? CSIZE_HI : CSIZE_LO;
      if (desc[1:0] == CSIZE_HI) desc[31:24] = opc;
      else desc[23:16] = opc;
    end
    push_item(ACC_WR, W_DESC, desc);
    push_item(ACC_WR, W_CTRL, $urandom | 32'h1);
    push_item(ACC_RD, W_D0, $urandom);
    if ($urandom_range(0, 1)) push_item(ACC_RD, W_D1, $urandom);
    if ($urandom_range(0, 2) == 0) push_item(ACC_RD, W_CTRL, $urandom);
    if ($urandom_range(0, 1)) push_item(ACC_RD, W_STAT, $urandom);
    if ($urandom_range(0, 2) == 0) begin
      push_item(ACC_WR, W_CLR, $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom);
    end
  endtask

  task automatic noise_item();
    logic [6:0] off;
    off = 7'($urandom_range(0, WIN_WORDS - 1));
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 6))
        0: off = W_CTRL;
        1: off = W_DESC;
        2: off = W_ADDR;
        3: off = W_D0;
        4: off = W_D1;
        5: off = W_STAT;
        default: off = W_CLR;
      endcase
    end
    push_item(1'($urandom_range(0, 1)), off, $urandom);
  endtask

  task automatic random_phase(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 70) flash_sequence();
      else noise_item();
    end
  endtask

  initial begin
    logic [23:0] idv;
    logic [31:0] rd;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    tag_typed   <= 1'b0;
    tag_rdata   <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    mismatches   = 0;
    items_sent   = 0;
    results_seen = 0;
    quiet_cycles = 0;
    jedec_val    = JEDEC_RST;
    foreach (win_img[i]) win_img[i] = '0;
    foreach (flash_img[i]) flash_img[i] = ERASED;
    probes = '{
      '{ACC_RD, W_STAT, 32'h0, 1'b1, 32'h0},
      '{ACC_WR, 7'(WIN_WORDS - 1), 32'hFFFF_FFFF, 1'b1, 32'h0},
      '{ACC_RD, 7'(WIN_WORDS - 1), 32'h0, 1'b1, 32'hFFFF_FFFF},
      '{ACC_RD, 7'd0, 32'hFFFF_FFFF, 1'b1, 32'h0},
      '{ACC_WR, W_DESC, mk_desc(CSIZE_HI, OPC_RDID, 4'd0), 1'b1, 32'h0},
      '{ACC_WR, W_CTRL, 32'h0000_0001, 1'b1, 32'h0},
      '{ACC_RD, W_D0, 32'h0, 1'b1, 32'h001A_5A9D},
      '{ACC_RD, W_STAT, 32'h0, 1'b1, 32'h0000_0001},
      '{ACC_RD, W_CTRL, 32'h0, 1'b1, 32'h0},
      '{ACC_WR, W_CLR, 32'hFFFF_FFFF, 1'b1, 32'h0},
      '{ACC_RD, W_STAT, 32'h0, 1'b1, 32'h0},
      '{ACC_RD, W_CLR, 32'h0, 1'b1, 32'h0},
      '{ACC_WR, W_DESC, mk_desc(CSIZE_LO, OPC_RDSR, 4'd0), 1'b1, 32'h0},
      '{ACC_WR, W_CTRL, 32'hFFFF_FFFF, 1'b1, 32'h0},
      '{ACC_RD, W_D0, 32'h0, 1'b1, 32'h0000_0002},
      '{ACC_WR, W_ADDR, 32'h0000_FFFC, 1'b1, 32'h0},
      '{ACC_WR, W_D0, 32'h0, 1'b1, 32'h0},
      '{ACC_WR, W_DESC, mk_desc(CSIZE_LO, OPC_PROG, 4'd15), 1'b1, 32'h0},
      '{ACC_WR, W_CTRL, 32'h0000_0001, 1'b1, 32'h0},
      '{ACC_WR, W_DESC, mk_desc(CSIZE_HI, OPC_READ, 4'd15), 1'b1, 32'h0},
      '{ACC_WR, W_CTRL, 32'h0000_0001, 1'b1, 32'h0},
      '{ACC_RD, W_D0, 32'h0, 1'b0, 32'h0},
      '{ACC_RD, W_D1, 32'h0, 1'b0, 32'h0},
      '{ACC_WR, W_DESC, mk_desc(CSIZE_LO, OPC_ERASE, 4'd0), 1'b1, 32'h0},
      '{ACC_WR, W_CTRL, 32'h0000_0001, 1'b1, 32'h0},
      '{ACC_RD, W_STAT, 32'h0, 1'b0, 32'h0}
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_PROBES; i++) begin
      push_item(probes[i].wr, probes[i].off, probes[i].data, probes[i].typed, probes[i].rdata);
    end
    random_phase(PHASE_ITEMS);

    for (int ph = 1; ph <= 4; ph++) begin
      wait_drained();
      repeat (SECTOR_BYTES_DEF + 64) @(posedge clk);
      case (ph)
        1: idv = 24'h00_0000;
        2: idv = 24'hFF_FFFF;
        default: idv = 24'($urandom_range(0, 24'hFF_FFFF));
      endcase
      cfg_access(1'b1, ADDR_JEDEC, {8'h00, idv}, rd);
      jedec_val = idv;
      cfg_access(1'b0, ADDR_JEDEC, '0, rd);
      if (rd !== {8'h00, idv}) report_mismatch("jedec_id readback", rd, {8'h00, idv});
      push_item(ACC_WR, W_DESC, mk_desc(CSIZE_HI, OPC_RDID, 4'd0));
      push_item(ACC_WR, W_CTRL, 32'h0000_0001);
      push_item(ACC_RD, W_D0, 32'h0);
      random_phase(PHASE_ITEMS);
    end

    wait_drained();
    repeat (SECTOR_BYTES_DEF + 64) @(posedge clk);
    if (mismatches == 0 && rdata_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: xspi_manual_command_nor_flash.f
+incdir+hw/rtl
hw/rtl/xspimc_pkg.sv
hw/rtl/xspimc_apb.sv
hw/rtl/xspimc_ctrl.sv
hw/rtl/xspimc_dp.sv
hw/rtl/xspi_manual_command_nor_flash.sv
hw/rtl/xspimc_chk.sv
dv/xspi_manual_command_nor_flash_tb.sv
